// File: rtl/assert_macros.svh
// Assertion helpers for the directory RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that an event implies a condition on the same edge.
`define ASSERT_IMPLY(label, ev, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ev) |-> (cond)) \
        else $error(msg);

`endif

// File: rtl/fecd_pkg.sv
package fecd_pkg;

    localparam int NUM_FILES_DEF = 128;
    localparam int ID_W          = 8;
    localparam int LANES         = 8;
    localparam int LANE_W        = 3;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_EVICT  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCESS,
        S_SCAN,
        S_EVRD,
        S_EVWR
    } t_state;

    // One memory row: eight directory entries.
    typedef struct packed {
        logic [LANES-1:0] vol;
        logic [LANES-1:0] pres;
    } t_row;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ram_ctl;

endpackage

// File: rtl/fecd_row_ram.sv
module fecd_row_ram #(
    parameter int NUM_ROWS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fecd_pkg::t_ram_ctl i_ctl,
    input  logic [((NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1)-1:0] i_rd_addr,
    input  logic [((NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1)-1:0] i_wr_addr,
    input  fecd_pkg::t_row  i_wr_row,
    output fecd_pkg::t_row  o_rd_row
);
    import fecd_pkg::*;

    t_row               r_mem [NUM_ROWS];
    logic [NUM_ROWS-1:0] r_valid;
    t_row               r_rd_data;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Rows never written read as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_row = r_rd_valid ? r_rd_data : '0;

endmodule

// File: rtl/farthest_entry_cache_directory_core.sv
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+-------------------------------
// command   | i_command, i_file_id, i_volume                 | taken when start && !busy
// result    | o_hit, o_hit_volume, o_victim_found,           | o_done high for one cycle,
//           | o_victim_id, o_victim_volume                   | no back-pressure
//
// Lookup, insert and unused codes do one row read, then raise the result strobe, in
// whose cycle the next word may already be accepted.
// Evict scans the row memory, one row of eight entries per cycle; when an entry can be
// freed, a read-modify-write then clears the victim, and when nothing is left an empty
// result is reported.
// Reset (synchronous, active low) clears all row valid bits at once, so the
// directory is empty on the first cycle after reset; there is no clearing pass.
// The receiver cannot stall: o_done is shown for exactly one cycle per result.
module farthest_entry_cache_directory_core #(
    parameter int NUM_FILES = fecd_pkg::NUM_FILES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_command,
    input  logic [7:0] i_file_id,
    input  logic       i_volume,
    output logic       o_done,
    output logic       o_hit,
    output logic       o_hit_volume,
    output logic       o_victim_found,
    output logic [7:0] o_victim_id,
    output logic       o_victim_volume
);
    import fecd_pkg::*;

    `include "assert_macros.svh"

    localparam int NUM_ROWS = (NUM_FILES + LANES - 1) / LANES;
    localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROWS - 1);

    t_state            r_state, n_state;
    logic [1:0]        r_cmd;
    logic [ID_W-1:0]   r_id;
    logic              r_vol;

    // scan bookkeeping
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_found, n_found;
    logic [ID_W-1:0]   r_best_dist, n_best_dist;
    logic [ID_W-1:0]   r_best_idx, n_best_idx;
    logic              r_best_vol, n_best_vol;

    // result registers
    logic              r_done, n_done;
    logic              r_hit, n_hit;
    logic              r_hit_vol, n_hit_vol;
    logic              r_vf, n_vf;
    logic [ID_W-1:0]   r_vid, n_vid;
    logic              r_vvol, n_vvol;

    // row memory port
    t_ram_ctl          ram_ctl;
    logic [ROW_W-1:0]  rd_addr, wr_addr;
    t_row              wr_row, rd_row;

    logic              accept;
    logic              in_range;
    logic [LANE_W-1:0] id_lane, best_lane;
    logic [ROW_W-1:0]  id_row, best_row;

    // running best after folding in the row being scanned
    logic              sc_found;
    logic [ID_W-1:0]   sc_dist, sc_idx;
    logic              sc_vol;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign in_range  = ({1'b0, r_id} < 9'(NUM_FILES));
    assign id_lane   = r_id[LANE_W-1:0];
    assign id_row    = ROW_W'(r_id >> LANE_W);
    assign best_lane = r_best_idx[LANE_W-1:0];
    assign best_row  = ROW_W'(r_best_idx >> LANE_W);

    fecd_row_ram #(
        .NUM_ROWS (NUM_ROWS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ram_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_row  (wr_row),
        .o_rd_row  (rd_row)
    );

    // Fold the eight entries of the current row into the running best, lowest
    // index first; a strictly greater distance is needed to replace, so ties
    // keep the lower index. The reference entry itself is skipped.
    always_comb begin
        logic [ID_W-1:0] idx;
        logic [ID_W-1:0] lane_dist;
        sc_found = r_found;
        sc_dist  = r_best_dist;
        sc_idx   = r_best_idx;
        sc_vol   = r_best_vol;
        for (int l = 0; l < LANES; l++) begin
            idx       = ID_W'({r_row, LANE_W'(l)});
            lane_dist = (idx > r_id) ? (idx - r_id) : (r_id - idx);
            if (rd_row.pres[l] && (idx != r_id) && (!sc_found || lane_dist > sc_dist)) begin
                sc_found = 1'b1;
                sc_dist  = lane_dist;
                sc_idx   = idx;
                sc_vol   = rd_row.vol[l];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_found     = r_found;
        n_best_dist = r_best_dist;
        n_best_idx  = r_best_idx;
        n_best_vol  = r_best_vol;
        n_done      = 1'b0;
        n_hit       = r_hit;
        n_hit_vol   = r_hit_vol;
        n_vf        = r_vf;
        n_vid       = r_vid;
        n_vvol      = r_vvol;
        ram_ctl     = '0;
        rd_addr     = r_row;
        wr_addr     = id_row;
        wr_row      = rd_row;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    ram_ctl.rd_en = 1'b1;
                    if (i_command == CMD_EVICT) begin
                        // start the scan at row zero with no candidate
                        rd_addr     = '0;
                        n_row       = '0;
                        n_found     = 1'b0;
                        n_best_dist = '0;
                        n_best_idx  = '0;
                        n_best_vol  = 1'b0;
                        n_state     = S_SCAN;
                    end else begin
                        rd_addr = ROW_W'(i_file_id >> LANE_W);
                        n_state = S_ACCESS;
                    end
                end
            end

            S_ACCESS: begin
                // row of the addressed entry is here: answer lookup, update insert
                n_done    = 1'b1;
                n_hit     = 1'b0;
                n_hit_vol = 1'b0;
                n_vf      = 1'b0;
                n_vid     = '0;
                n_vvol    = 1'b0;
                if (in_range && r_cmd == CMD_LOOKUP) begin
                    n_hit     = rd_row.pres[id_lane];
                    n_hit_vol = rd_row.pres[id_lane] && rd_row.vol[id_lane];
                end
                if (in_range && r_cmd == CMD_INSERT) begin
                    ram_ctl.wr_en         = 1'b1;
                    wr_row.vol[id_lane]  = r_vol;
                    wr_row.pres[id_lane] = 1'b1;
                end
                n_state = S_IDLE;
            end

            S_SCAN: begin
                n_found     = sc_found;
                n_best_dist = sc_dist;
                n_best_idx  = sc_idx;
                n_best_vol  = sc_vol;
                if (r_row == LAST_ROW) begin
                    if (sc_found) begin
                        n_state = S_EVRD;
                    end else begin
                        // nothing to free: report an empty result
                        n_done    = 1'b1;
                        n_hit     = 1'b0;
                        n_hit_vol = 1'b0;
                        n_vf      = 1'b0;
                        n_vid     = '0;
                        n_vvol    = 1'b0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    // prefetch the next row
                    ram_ctl.rd_en = 1'b1;
                    rd_addr       = r_row + 1'b1;
                    n_row         = r_row + 1'b1;
                end
            end

            S_EVRD: begin
                ram_ctl.rd_en = 1'b1;
                rd_addr       = best_row;
                n_state       = S_EVWR;
            end

            S_EVWR: begin
                // drop the victim from its row and report it
                ram_ctl.wr_en          = 1'b1;
                wr_addr                = best_row;
                wr_row.pres[best_lane] = 1'b0;
                wr_row.vol[best_lane]  = 1'b0;
                n_done    = 1'b1;
                n_hit     = 1'b0;
                n_hit_vol = 1'b0;
                n_vf      = 1'b1;
                n_vid     = r_best_idx;
                n_vvol    = r_best_vol;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Hold the command word and the scan and result payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_id  <= i_file_id;
            r_vol <= i_volume;
        end
        r_row       <= n_row;
        r_found     <= n_found;
        r_best_dist <= n_best_dist;
        r_best_idx  <= n_best_idx;
        r_best_vol  <= n_best_vol;
        r_hit       <= n_hit;
        r_hit_vol   <= n_hit_vol;
        r_vf        <= n_vf;
        r_vid       <= n_vid;
        r_vvol      <= n_vvol;
    end

    assign o_done          = r_done;
    assign o_hit           = r_hit;
    assign o_hit_volume    = r_hit_vol;
    assign o_victim_found  = r_vf;
    assign o_victim_id     = r_vid;
    assign o_victim_volume = r_vvol;

    // A result only follows a command that was being worked on.
    `ASSERT_IMPLY(a_done_after_busy, o_done, $past(busy), "result strobe without a command")
    // A freed entry always lies inside the directory.
    `ASSERT_IMPLY(a_victim_in_range, o_done && o_victim_found,
                  {1'b0, o_victim_id} < 9'(NUM_FILES), "victim outside directory")
    // Lookup and evict results never mix.
    `ASSERT_IMPLY(a_hit_excl, o_hit, !o_victim_found, "hit and victim reported together")
    // The scan row counter stays within the memory.
    `ASSERT_CLK(a_row_bound, (r_state != S_SCAN) || (r_row <= LAST_ROW), "scan past last row")

endmodule
